// ===== rtl/rscf_pkg.sv =====
// Shared constants, register map and types for the restriction site cut finder.
`timescale 1ns / 1ps
`default_nettype none

package rscf_pkg;

    localparam int MAX_LEN_DEF   = 12;
    localparam int NUM_SITES_DEF = 4;
    localparam int REG_SITES     = 4;
    localparam int PAT_BASES     = 12;
    localparam int PAT_W         = 2 * PAT_BASES;
    localparam int RES_LIMIT     = 12;
    localparam int RES_CNT_W     = 4;
    localparam int SITE_W        = 36;
    localparam int CNT_W         = 32;
    localparam int BASE_W        = 3;
    localparam int FLD_W         = 4;
    localparam int LEN_LSB       = 24;
    localparam int CUT_LSB       = 28;
    localparam int SKIP_LSB      = 32;
    localparam int SITE_IDX_W    = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int SUSE_W        = 3;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [BASE_W-1:0] BASE_NONE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SITE_A       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_B       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_C       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_D       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SITES_IN_USE = 3'd4;

    localparam logic [SUSE_W-1:0] SITES_IN_USE_RST = 3'd1;

    typedef struct packed {
        logic                  hit;
        logic [SITE_IDX_W-1:0] site;
    } t_pick;

    typedef struct packed {
        logic [CNT_W-1:0]      cut;
        logic [SITE_IDX_W-1:0] site;
        logic                  cut_valid;
        logic                  done;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/rscf_cell.sv =====
// One window cell: holds a base, shifts it on from its neighbor, compares it to every pattern base.
`timescale 1ns / 1ps
`default_nettype none

module rscf_cell #(
    parameter int LANES = rscf_pkg::REG_SITES
) (
    input  wire logic                                                 i_clk,
    input  wire logic                                                 i_rst_n,
    input  wire logic                                                 i_shift,
    input  wire logic                                                 i_clear,
    input  wire logic [rscf_pkg::BASE_W-1:0]                          i_base,
    input  wire logic [LANES-1:0][rscf_pkg::PAT_W-1:0]                i_pat,
    output logic      [rscf_pkg::BASE_W-1:0]                          o_base,
    output logic      [LANES-1:0][rscf_pkg::PAT_BASES-1:0]            o_eq
);

    logic [rscf_pkg::BASE_W-1:0] r_base;
    logic [rscf_pkg::BASE_W-1:0] n_base;

    always_comb begin
        n_base = r_base;
        if (i_clear) begin
            n_base = rscf_pkg::BASE_NONE;
        end else if (i_shift) begin
            n_base = i_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= rscf_pkg::BASE_NONE;
        end else begin
            r_base <= n_base;
        end
    end

    // codes 4..7 carry the top bit and never match
    always_comb begin
        for (int s = 0; s < LANES; s++) begin
            for (int t = 0; t < rscf_pkg::PAT_BASES; t++) begin
                o_eq[s][t] = !r_base[rscf_pkg::BASE_W-1] && (r_base[1:0] == i_pat[s][2*t +: 2]);
            end
        end
    end

    assign o_base = r_base;

endmodule

`default_nettype wire

// ===== rtl/rscf_pick.sv =====
// Site matcher for one window offset: full-match test per site and lowest-index pick.
`timescale 1ns / 1ps
`default_nettype none

module rscf_pick #(
    parameter int MAX_LEN = rscf_pkg::MAX_LEN_DEF,
    parameter int LANES   = rscf_pkg::REG_SITES,
    parameter int OFF     = 0
) (
    input  wire logic [MAX_LEN-1:0][LANES-1:0][rscf_pkg::PAT_BASES-1:0] i_eq,
    input  wire logic [LANES-1:0][rscf_pkg::FLD_W-1:0]                  i_len,
    input  wire logic [LANES-1:0]                                       i_active,
    output rscf_pkg::t_pick                                             o_pick
);

    localparam int ROOM  = MAX_LEN - OFF;
    localparam int LEN_W = rscf_pkg::FLD_W;
    localparam int IDX_W = rscf_pkg::SITE_IDX_W;

    logic [LANES-1:0][rscf_pkg::PAT_BASES-1:0] w_ok;
    logic [LANES-1:0][rscf_pkg::PAT_BASES-1:0] w_need;
    logic [LANES-1:0]                          w_lane_ok;
    logic [LANES-1:0]                          w_match;

    for (genvar s = 0; s < LANES; s++) begin : g_lane
        for (genvar t = 0; t < rscf_pkg::PAT_BASES; t++) begin : g_base
            if (OFF + t < MAX_LEN) begin : g_in
                assign w_ok[s][t] = i_eq[OFF+t][s][t];
            end else begin : g_out
                assign w_ok[s][t] = 1'b0;
            end
            assign w_need[s][t] = LEN_W'(t) < i_len[s];
        end
        // a site longer than the bases left from this offset cannot match
        assign w_lane_ok[s] = i_active[s] && (i_len[s] != '0)
                           && (int'(i_len[s]) <= rscf_pkg::PAT_BASES)
                           && (int'(i_len[s]) <= ROOM);
        assign w_match[s] = w_lane_ok[s] && (&(w_ok[s] | ~w_need[s]));
    end

    always_comb begin
        o_pick = '0;
        for (int s = LANES - 1; s >= 0; s--) begin
            if (w_match[s]) begin
                o_pick.hit  = 1'b1;
                o_pick.site = IDX_W'(s);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rscf_out_fifo.sv =====
// Two-entry result queue that decouples the decision logic from the result stream.
`timescale 1ns / 1ps
`default_nettype none

module rscf_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rscf_pkg::t_result i_data,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output rscf_pkg::t_result      o_data,
    output logic [1:0]             o_count
);

    rscf_pkg::t_result r_mem [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic              w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;
    assign w_pop   = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= 2'(r_cnt + {1'b0, i_push} - {1'b0, w_pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/restriction_site_cut_finder_unit.sv =====
// Restriction site cut finder top level: window cell chain, site matchers, flush sequencer.
// A cut is decided from the registered window after the base that fills it and queued for m_axis.
// One base per cycle with queue room; the next-allowed-start compare and add are combinational.
// A final base holds s_axis while the flush decides one window offset per cycle with queue room.
// Reset (sync, active low): window to no-base, counters and queue empty, sites cleared, one in use.
`timescale 1ns / 1ps
`default_nettype none

module restriction_site_cut_finder_unit #(
    parameter int MAX_LEN   = rscf_pkg::MAX_LEN_DEF,
    parameter int NUM_SITES = rscf_pkg::NUM_SITES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [rscf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [2:0] base_code
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [31:0] cut_position, [33:32] site_number
    output logic [rscf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic [0:0]                               m_axis_tuser,  // [0] cut_valid
    output logic                                     m_axis_tlast,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [rscf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rscf_pkg::SITE_W-1:0]         i_cfg_data
);

    localparam int LANES  = (NUM_SITES < rscf_pkg::REG_SITES) ? NUM_SITES : rscf_pkg::REG_SITES;
    localparam int FW     = $clog2(MAX_LEN + 1);
    localparam int OW     = $clog2(MAX_LEN);
    localparam int CW     = rscf_pkg::CNT_W;
    localparam int NW     = rscf_pkg::RES_CNT_W;
    localparam int SUW    = rscf_pkg::SUSE_W;
    localparam int FLW    = rscf_pkg::FLD_W;

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_END  = 2'd2;

    // configuration
    logic [rscf_pkg::SITE_W-1:0] r_site [rscf_pkg::REG_SITES];
    logic [SUW-1:0]              r_sites_in_use;

    // run state
    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_next, n_next;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_pend, n_pend;
    logic          r_pend_fin, n_pend_fin;
    logic          r_hold_v, n_hold_v;
    logic [NW-1:0] r_n, n_n;
    logic [OW-1:0] r_off, n_off;
    logic [CW-1:0] r_start, n_start;
    rscf_pkg::t_result r_hold, n_hold;

    logic w_accept;
    logic w_pop;
    logic w_clear;
    logic w_can_push;
    logic [2:0] w_occ;
    logic [1:0] q_cnt;
    logic       w_push;
    rscf_pkg::t_result w_push_data;
    rscf_pkg::t_result q_data;

    logic [MAX_LEN-1:0][rscf_pkg::BASE_W-1:0]                 w_base;
    logic [MAX_LEN-1:0][rscf_pkg::BASE_W-1:0]                 w_base_in;
    logic [MAX_LEN-1:0][LANES-1:0][rscf_pkg::PAT_BASES-1:0]   w_eq;
    logic [LANES-1:0][rscf_pkg::PAT_W-1:0]                    w_pat;
    logic [LANES-1:0][FLW-1:0]                                w_len;
    logic [LANES-1:0]                                         w_active;
    rscf_pkg::t_pick                                          w_pick [MAX_LEN];

    rscf_pkg::t_pick             w_pick_sel;
    logic [CW-1:0]               w_start;
    logic [rscf_pkg::SITE_W-1:0] w_word;
    logic [FLW-1:0]              w_skip;
    logic [FLW-1:0]              w_skip_eff;
    logic [CW-1:0]               w_skip_start;
    logic                        w_hit;
    rscf_pkg::t_result           w_found;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rscf_pkg::REG_SITES; k++) begin
                r_site[k] <= '0;
            end
            r_sites_in_use <= rscf_pkg::SITES_IN_USE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rscf_pkg::CFG_SITE_A:       r_site[0] <= i_cfg_data;
                rscf_pkg::CFG_SITE_B:       r_site[1] <= i_cfg_data;
                rscf_pkg::CFG_SITE_C:       r_site[2] <= i_cfg_data;
                rscf_pkg::CFG_SITE_D:       r_site[3] <= i_cfg_data;
                rscf_pkg::CFG_SITES_IN_USE: r_sites_in_use <= i_cfg_data[SUW-1:0];
                default: begin
                end
            endcase
        end
    end

    for (genvar s = 0; s < LANES; s++) begin : g_lane
        assign w_pat[s]    = r_site[s][rscf_pkg::PAT_W-1:0];
        assign w_len[s]    = r_site[s][rscf_pkg::LEN_LSB +: FLW];
        assign w_active[s] = SUW'(s) < r_sites_in_use;
    end

    // window: cell 0 holds the oldest base, the newest enters at the far end
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        if (i == MAX_LEN - 1) begin : g_tail
            assign w_base_in[i] = s_axis_tdata[rscf_pkg::BASE_W-1:0];
        end else begin : g_body
            assign w_base_in[i] = w_base[i+1];
        end

        rscf_cell #(
            .LANES (LANES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_clear (w_clear),
            .i_base  (w_base_in[i]),
            .i_pat   (w_pat),
            .o_base  (w_base[i]),
            .o_eq    (w_eq[i])
        );

        rscf_pick #(
            .MAX_LEN (MAX_LEN),
            .LANES   (LANES),
            .OFF     (i)
        ) u_pick (
            .i_eq     (w_eq),
            .i_len    (w_len),
            .i_active (w_active),
            .o_pick   (w_pick[i])
        );
    end

    // handshake and queue credit
    assign w_accept   = s_axis_tvalid & s_axis_tready;
    assign w_pop      = m_axis_tvalid & m_axis_tready;
    assign w_occ      = {1'b0, q_cnt} + {2'b00, r_pend} - {2'b00, w_pop};
    assign w_can_push = (q_cnt != 2'd2) | w_pop;
    assign s_axis_tready = (r_state == S_RUN) && !(r_pend && r_pend_fin) && (w_occ <= 3'd1);

    // decision for one start: offset 0 in a run, the scan offset during a flush
    assign w_pick_sel   = (r_state == S_SCAN) ? w_pick[r_off] : w_pick[0];
    assign w_start      = (r_state == S_SCAN) ? r_start : (r_cnt - CW'(MAX_LEN));
    assign w_word       = r_site[w_pick_sel.site];
    assign w_skip       = w_word[rscf_pkg::SKIP_LSB +: FLW];
    assign w_skip_eff   = (w_skip == '0) ? FLW'(1) : w_skip;
    assign w_skip_start = w_start + {{(CW-FLW){1'b0}}, w_skip_eff};
    assign w_hit        = w_pick_sel.hit && (w_start >= r_next);

    always_comb begin
        w_found           = '0;
        w_found.cut       = w_start + {{(CW-FLW){1'b0}}, w_word[rscf_pkg::CUT_LSB +: FLW]};
        w_found.site      = w_pick_sel.site;
        w_found.cut_valid = 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_next      = r_next;
        n_fill      = r_fill;
        n_pend      = 1'b0;
        n_pend_fin  = r_pend_fin;
        n_hold_v    = r_hold_v;
        n_hold      = r_hold;
        n_n         = r_n;
        n_off       = r_off;
        n_start     = r_start;
        w_clear     = 1'b0;
        w_push      = 1'b0;
        w_push_data = w_found;

        unique case (r_state)
            S_RUN: begin
                n_pend = w_accept;
                if (w_accept) begin
                    n_pend_fin = s_axis_tlast;
                    n_cnt      = r_cnt + CW'(1);
                    if (r_fill != FW'(MAX_LEN)) begin
                        n_fill = r_fill + FW'(1);
                    end
                end
                if (r_pend && !r_pend_fin) begin
                    if ((r_fill == FW'(MAX_LEN)) && w_hit) begin
                        w_push = 1'b1;
                        n_next = w_skip_start;
                    end
                end else if (r_pend && r_pend_fin) begin
                    // start the flush at the oldest base of this run
                    n_state  = S_SCAN;
                    n_off    = OW'(FW'(MAX_LEN) - r_fill);
                    n_start  = r_cnt - {{(CW-FW){1'b0}}, r_fill};
                    n_n      = '0;
                    n_hold_v = 1'b0;
                end
            end
            S_SCAN: begin
                if (w_can_push) begin
                    if (w_hit) begin
                        // hold the newest cut so the last one can carry the done mark
                        w_push_data = r_hold;
                        w_push      = r_hold_v;
                        n_hold      = w_found;
                        n_hold_v    = 1'b1;
                        n_next      = w_skip_start;
                        n_n         = r_n + NW'(1);
                    end
                    if ((w_hit && (NW'(r_n + NW'(1)) == NW'(rscf_pkg::RES_LIMIT)))
                        || (r_off == OW'(MAX_LEN - 1))) begin
                        n_state = S_END;
                    end else begin
                        n_off   = r_off + OW'(1);
                        n_start = r_start + CW'(1);
                    end
                end
            end
            S_END: begin
                if (w_can_push) begin
                    w_push = 1'b1;
                    if (r_hold_v) begin
                        w_push_data      = r_hold;
                        w_push_data.done = 1'b1;
                    end else begin
                        w_push_data      = '0;
                        w_push_data.done = 1'b1;
                    end
                    n_state  = S_RUN;
                    w_clear  = 1'b1;
                    n_cnt    = '0;
                    n_next   = '0;
                    n_fill   = '0;
                    n_hold_v = 1'b0;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RUN;
            r_cnt      <= '0;
            r_next     <= '0;
            r_fill     <= '0;
            r_pend     <= 1'b0;
            r_pend_fin <= 1'b0;
            r_hold_v   <= 1'b0;
            r_n        <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_next     <= n_next;
            r_fill     <= n_fill;
            r_pend     <= n_pend;
            r_pend_fin <= n_pend_fin;
            r_hold_v   <= n_hold_v;
            r_n        <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off   <= n_off;
        r_start <= n_start;
        r_hold  <= n_hold;
    end

    rscf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data),
        .o_count (q_cnt)
    );

    assign m_axis_tdata = {{(rscf_pkg::OUT_TDATA_W - CW - rscf_pkg::SITE_IDX_W){1'b0}},
                           q_data.site, q_data.cut};
    assign m_axis_tuser = q_data.cut_valid;
    assign m_axis_tlast = q_data.done;

    a_hold_input_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> !s_axis_tready)
        else $error("input taken while a flush is in progress");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (q_cnt == 2'd2)) |-> w_pop)
        else $error("result pushed into a full queue");

    a_done_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_push_data.done) |-> (r_state == S_END))
        else $error("done mark outside the end of a flush");

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_END) && w_can_push) |=> ((r_cnt == '0) && (r_fill == '0)
                                                && (r_state == S_RUN)))
        else $error("run state not cleared after a flush");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the restriction site cut finder: directed, stall and random runs.
`timescale 1ns / 1ps

module tb_top;
    import rscf_pkg::*;

    localparam int WIN = MAX_LEN_DEF;

    localparam logic [BASE_W-1:0] BASE_A = 3'd0;
    localparam logic [BASE_W-1:0] BASE_C = 3'd1;
    localparam logic [BASE_W-1:0] BASE_G = 3'd2;
    localparam logic [BASE_W-1:0] BASE_T = 3'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [2:0] base_code
    logic                   s_axis_tlast;   // final_base
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] cut_position, [33:32] site_number
    logic [0:0]             m_axis_tuser;   // [0] cut_valid
    logic                   m_axis_tlast;   // sequence_done
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [SITE_W-1:0]      i_cfg_data;

    always #10 i_clk = ~i_clk;

    restriction_site_cut_finder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Cut predictor state
    logic [BASE_W-1:0] win_bases [WIN];
    logic [CNT_W-1:0]  base_count;
    logic [CNT_W-1:0]  allowed_start;
    int unsigned       win_fill;
    logic [SITE_W-1:0] site_words [REG_SITES];
    logic [SUSE_W-1:0] sites_in_use_cfg;
    t_result           pending_cuts [$];

    int mismatches;
    int bases_sent;
    int cuts_seen;
    int runs_ended;
    int cfg_writes;
    bit sender_gaps;
    bit rx_stalls;
    int rx_hold_cycles;

    function automatic void clear_run_state();
        foreach (win_bases[i]) win_bases[i] = BASE_NONE;
        base_count    = '0;
        allowed_start = '0;
        win_fill      = 0;
    endfunction

    function automatic bit site_hit(logic [SITE_W-1:0] w, int off);
        int len;
        len = int'(w[LEN_LSB +: FLD_W]);
        if (len == 0 || len > PAT_BASES || len > WIN) return 1'b0;
        for (int i = 0; i < len; i++) begin
            if (off + i >= WIN) return 1'b0;
            if (win_bases[off + i] > BASE_T) return 1'b0;
            if (win_bases[off + i][1:0] != w[2 * i +: 2]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Lowest active site wins; its skip (zero taken as one) moves the next allowed start.
    function automatic void decide_start(int off, logic [CNT_W-1:0] start);
        int                n_act;
        logic [CNT_W-1:0]  cut_off;
        logic [CNT_W-1:0]  step;
        t_result           r;
        n_act = int'(sites_in_use_cfg);
        if (n_act > REG_SITES) n_act = REG_SITES;
        if (n_act > NUM_SITES_DEF) n_act = NUM_SITES_DEF;
        if (start < allowed_start) return;
        for (int j = 0; j < n_act; j++) begin
            if (site_hit(site_words[j], off)) begin
                cut_off       = CNT_W'(site_words[j][CUT_LSB +: FLD_W]);
                step          = CNT_W'(site_words[j][SKIP_LSB +: FLD_W]);
                r.cut         = start + cut_off;
                r.site        = SITE_IDX_W'(j);
                r.cut_valid   = 1'b1;
                r.done        = 1'b0;
                pending_cuts.insert(pending_cuts.size(), r);
                allowed_start = start + ((step == '0) ? CNT_W'(1) : step);
                return;
            end
        end
    endfunction

    function automatic void predict_cuts(logic [BASE_W-1:0] code, logic fin);
        logic [CNT_W-1:0] prev_count;
        int               n0;
        t_result          r;
        prev_count = base_count;
        for (int i = 0; i < WIN - 1; i++) win_bases[i] = win_bases[i + 1];
        win_bases[WIN - 1] = code;
        base_count = base_count + 1;
        if (win_fill < WIN) win_fill++;
        if (!fin) begin
            if (win_fill >= WIN) decide_start(0, prev_count - (WIN - 1));
            return;
        end
        // Flush: decide each start still pending against the bases present, up to RES_LIMIT cuts
        n0 = pending_cuts.size();
        for (int off = WIN - int'(win_fill);
             off < WIN && pending_cuts.size() - n0 < RES_LIMIT; off++)
            decide_start(off, prev_count - (WIN - 1) + off);
        if (pending_cuts.size() == n0) begin
            r      = '0;
            r.done = 1'b1;
            pending_cuts.insert(pending_cuts.size(), r);
        end else begin
            pending_cuts[pending_cuts.size() - 1].done = 1'b1;
        end
        clear_run_state();
    endfunction

    function automatic void report_mismatch(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: want cut %0d site %0d valid %0b done %0b, %s",
                     $time, what, want.cut, want.site, want.cut_valid, want.done,
                     $sformatf("got cut %0d site %0d valid %0b done %0b",
                               got.cut, got.site, got.cut_valid, got.done));
    endfunction

    function automatic void check_cut();
        t_result got;
        t_result want;
        got.cut       = m_axis_tdata[CNT_W-1:0];
        got.site      = m_axis_tdata[CNT_W +: SITE_IDX_W];
        got.cut_valid = m_axis_tuser[0];
        got.done      = m_axis_tlast;
        if (got.cut_valid) cuts_seen++;
        if (got.done) runs_ended++;
        if (pending_cuts.size() == 0) begin
            report_mismatch("result with none pending", '0, got);
            return;
        end
        want = pending_cuts[0];
        pending_cuts.delete(0);
        if (got.cut != want.cut) report_mismatch("cut_position", want, got);
        else if (got.site != want.site) report_mismatch("site_number", want, got);
        else if (got.cut_valid != want.cut_valid) report_mismatch("cut_valid", want, got);
        else if (got.done != want.done) report_mismatch("sequence_done", want, got);
    endfunction

    // Predict first so a same-edge result always finds its entry
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_cuts(s_axis_tdata[BASE_W-1:0], s_axis_tlast);
                bases_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) check_cut();
        end
    end

    // Result sink: random stall bursts, plus a long hold on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [BASE_W-1:0] code_of(byte ch);
        case (ch)
            "A": return BASE_A;
            "C": return BASE_C;
            "G": return BASE_G;
            "T": return BASE_T;
            default: return BASE_NONE;
        endcase
    endfunction

    function automatic logic [SITE_W-1:0] site_of(string s, int cut, int skip);
        logic [PAT_W-1:0]  pat;
        logic [BASE_W-1:0] c;
        pat = '0;
        for (int i = 0; i < s.len(); i++) begin
            c = code_of(s[i]);
            pat[2 * i +: 2] = c[1:0];
        end
        return {FLD_W'(skip), FLD_W'(cut), FLD_W'(s.len()), pat};
    endfunction

    function automatic logic [SITE_W-1:0] random_site();
        int r;
        int len;
        r = $urandom_range(0, 9);
        if (r == 0) len = 0;
        else if (r == 1) len = $urandom_range(PAT_BASES, 15);
        else len = $urandom_range(1, 4);
        return {FLD_W'($urandom_range(0, 15)), FLD_W'($urandom_range(0, 15)),
                FLD_W'(len), PAT_W'($urandom())};
    endfunction

    // Raise valid at the next falling edge after entry so back-to-back writes keep valid low between them
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SITE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_SITES_IN_USE) sites_in_use_cfg = val[SUSE_W-1:0];
        else if (idx < CFG_SITES_IN_USE) site_words[idx] = val;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_sites(logic [SITE_W-1:0] a, logic [SITE_W-1:0] b,
                              logic [SITE_W-1:0] c, logic [SITE_W-1:0] d,
                              logic [SUSE_W-1:0] n_used);
        write_reg(CFG_SITE_A, a);
        write_reg(CFG_SITE_B, b);
        write_reg(CFG_SITE_C, c);
        write_reg(CFG_SITE_D, d);
        write_reg(CFG_SITES_IN_USE, SITE_W'(n_used));
    endtask

    // Enter and leave at a falling edge; valid stays high for back-to-back transfers
    task automatic send_base(logic [BASE_W-1:0] code, logic fin);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(code);
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_string(string s, bit fin_at_end);
        for (int i = 0; i < s.len(); i++)
            send_base(code_of(s[i]), fin_at_end && i == s.len() - 1);
    endtask

    // Drop valid, let every pending cut arrive, then allow the pipeline to settle
    task automatic drain_cuts();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_cuts.size() != 0);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic test_reset_state();
        // Sites cleared by reset: only bare end marks
        send_string("A", 1'b1);
        send_string("CN", 1'b1);
        drain_cuts();
    endtask

    task automatic test_directed_sites();
        load_sites(site_of("GAATTC", 1, 6), site_of("TTTTTTTTTTTT", 15, 15),
                   {SITE_W{1'b1}}, site_of("A", 0, 0), SUSE_W'(4));
        // Last GAAT runs past the final base
        send_string("GAATTCTTTTTTTTTTTTNAGAAT", 1'b1);
        drain_cuts();
    endtask

    task automatic test_site_count_extremes();
        write_reg(CFG_SITES_IN_USE, '0);
        send_string("AA", 1'b1);
        drain_cuts();
        write_reg(CFG_SITES_IN_USE, {SITE_W{1'b1}});
        send_string("GAATTCA", 1'b1);
        drain_cuts();
    endtask

    task automatic test_output_backpressure();
        load_sites(site_of("A", 15, 0), '0, '0, '0, SUSE_W'(1));
        sender_gaps    = 1'b0;
        rx_hold_cycles = 150;
        for (int i = 0; i < 30; i++) send_base(BASE_A, 1'b0);
        // Pause mid-run until every cut so far has come out
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_cuts.size() != 0);
        for (int i = 0; i < 10; i++) send_base(BASE_A, i == 9);
        drain_cuts();
    endtask

    task automatic send_random_run(int n_bases);
        logic [BASE_W-1:0] plan [$];
        logic [SITE_W-1:0] w;
        logic [BASE_W-1:0] code;
        int                len;
        for (int k = 0; k < n_bases; k++) begin
            // Plant a copy of a configured site now and then
            if (plan.size() == 0 && $urandom_range(0, 2) == 0) begin
                w   = site_words[$urandom_range(0, REG_SITES - 1)];
                len = int'(w[LEN_LSB +: FLD_W]);
                if (len > PAT_BASES) len = PAT_BASES;
                for (int i = 0; i < len; i++) plan.insert(plan.size(), BASE_W'(w[2 * i +: 2]));
            end
            if (plan.size() != 0) begin
                code = plan[0];
                plan.delete(0);
            end
            else if ($urandom_range(0, 15) < 13) code = BASE_W'($urandom_range(0, 3));
            else code = BASE_W'($urandom_range(4, 7));
            send_base(code, k == n_bases - 1);
        end
    endtask

    task automatic test_random_phases();
        int phase_start;
        int run_len;
        for (int phase = 0; phase < 5; phase++) begin
            load_sites(random_site(), random_site(), random_site(), random_site(),
                       ($urandom_range(0, 9) < 8) ? SUSE_W'($urandom_range(1, 4))
                                                  : SUSE_W'($urandom_range(0, 7)));
            rx_stalls   = (phase < 4) && ($urandom_range(0, 3) != 0);
            phase_start = bases_sent;
            while (bases_sent - phase_start < 60) begin
                sender_gaps = (phase < 4) && ($urandom_range(0, 3) != 0);
                run_len = ($urandom_range(0, 9) < 3) ? $urandom_range(1, WIN - 1)
                                                     : $urandom_range(WIN, 40);
                send_random_run(run_len);
            end
            drain_cuts();
        end
    endtask

    initial begin
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tlast     = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_SITE_A;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        sender_gaps      = 1'b1;
        rx_stalls        = 1'b1;
        rx_hold_cycles   = 0;
        sites_in_use_cfg = SITES_IN_USE_RST;
        foreach (site_words[i]) site_words[i] = '0;
        clear_run_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_directed_sites();
        test_site_count_extremes();
        test_output_backpressure();
        test_random_phases();
        drain_cuts();

        $display("Covered %0d bases in %0d runs, %0d cuts, %0d register writes",
                 bases_sent, runs_ended, cuts_seen, cfg_writes);
        $display("Scope: reset sites, directed sites, site-count extremes, output stall, random sets");
        if (mismatches == 0 && pending_cuts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Mismatches %0d, results still pending %0d", mismatches, pending_cuts.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
